// File: hdl/assert_macros.svh
// Assertion macros shared by the compensation block RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define BSC_ASSERT(name, prop, clk, rst_n) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Condition must never be seen at a clock edge outside reset.
`define BSC_ASSERT_NEVER(name, cond, clk, rst_n) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define BSC_ASSERT(name, prop, clk, rst_n)
`define BSC_ASSERT_NEVER(name, cond, clk, rst_n)
`endif
`endif

// File: hdl/bsc_pkg.sv
// Shared widths, register indexes and payload types of the compensation block.
`timescale 1ns / 1ps
package bsc_pkg;

  localparam int DATA_W    = 32;
  localparam int RAW_W     = 19;
  localparam int OSS_W     = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_W     = $clog2(DATA_W);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_AC1_AC2  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AC3_AC4  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AC5_AC6  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B1_B2    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MC_MD    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OVERSAMP = 3'd5;

  typedef struct packed {
    logic             kind;
    logic [RAW_W-1:0] raw_value;
  } in_item_t;

  typedef struct packed {
    logic                     result_kind;
    logic signed [DATA_W-1:0] value;
    logic                     div_error;
  } out_item_t;

endpackage

// File: hdl/baro_sensor_compensation.sv
// Integer temperature and pressure compensation for a barometric sensor.
//
// Requests enter on in_valid_i/in_stall_o/in_data_i: kind 0 carries a raw
// temperature, kind 1 a raw pressure. Each request gives one result on
// out_valid_o/out_stall_i/out_data_o: temperature in 0.1 degC or pressure in
// Pa, with div_error set and value 0 when a divisor turned out zero.
// A temperature request with a nonzero divisor also updates the stored B5
// term used by later pressure requests. Calibration words are written through
// cfg_we_i, cfg_idx_i and cfg_wdata_i; the user must write them only while
// no request is in flight, as the block itself does not enforce this.
// The bit-serial divider takes most of the time from accept to result valid,
// and a zero divisor skips it; the rest is one step of the shared 32x32
// multiplier or adder per cycle. One request is in flight at a time, and the
// next one is taken the cycle after the result moves into the output
// register, even if that result is still stalled. A stalled result holds
// its value; a finished result waits until the output register is free.
// Reset clears the coefficients, sets oversampling to 3 and B5 to zero.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module baro_sensor_compensation (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  bsc_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output bsc_pkg::out_item_t           out_data_o,
  input  logic                         cfg_we_i,
  input  logic [bsc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bsc_pkg::DATA_W-1:0]    cfg_wdata_i
);

  localparam int W     = bsc_pkg::DATA_W;
  localparam int PAD_W = bsc_pkg::DATA_W - bsc_pkg::RAW_W;

  localparam logic [W-1:0] T_OFFSET  = 32'd4000;
  localparam logic [W-1:0] B4_BIAS   = 32'd32768;
  localparam logic [W-1:0] P_SCALE   = 32'd50000;
  localparam logic [W-1:0] K_SQ      = 32'd3038;
  localparam logic [W-1:0] K_LIN     = 32'hFFFF_E343;  // -7357
  localparam logic [W-1:0] K_OFS     = 32'd3791;
  localparam logic [W-1:0] T_ROUND   = 32'd8;
  localparam logic [W-1:0] B_ROUND   = 32'd2;

  typedef enum logic [23:0] {
    S_IDLE  = 24'h00_0001,
    S_T_X1  = 24'h00_0002,
    S_T_DEN = 24'h00_0004,
    S_T_CHK = 24'h00_0008,
    S_T_DIV = 24'h00_0010,
    S_T_VAL = 24'h00_0020,
    S_P_SQ  = 24'h00_0040,
    S_P_X1  = 24'h00_0080,
    S_P_X2  = 24'h00_0100,
    S_P_B3A = 24'h00_0200,
    S_P_B3B = 24'h00_0400,
    S_P_B3C = 24'h00_0800,
    S_P_B4A = 24'h00_1000,
    S_P_B4B = 24'h00_2000,
    S_P_B4C = 24'h00_4000,
    S_P_CHK = 24'h00_8000,
    S_P_DIV = 24'h01_0000,
    S_P_C1  = 24'h02_0000,
    S_P_C2  = 24'h04_0000,
    S_P_C3  = 24'h08_0000,
    S_P_C4  = 24'h10_0000,
    S_P_C5  = 24'h20_0000,
    S_P_VAL = 24'h40_0000,
    S_DONE  = 24'h80_0000
  } state_e;

  function automatic logic [W-1:0] sra32(input logic [W-1:0] v, input logic [4:0] sh);
    return 32'($signed(v) >>> sh);
  endfunction

  state_e state_q, state_d;

  logic [W-1:0]              ac12_q, ac34_q, ac56_q, b12_q, mcmd_q;
  logic [bsc_pkg::OSS_W-1:0] oss_q;
  logic [W-1:0]              temp_term_q;
  logic                      out_valid_q;
  bsc_pkg::out_item_t        out_data_q;

  logic                      kind_q;
  logic [bsc_pkg::RAW_W-1:0] raw_q;
  logic [W-1:0]              a_q, sq_q, r1_q, r2_q, r3_q, val_q;
  logic                      err_q;

  logic [W-1:0] ac1_s, ac2_s, ac3_s, ac4_u, ac5_u, ac6_u, b1_s, b2_s, mc_s, md_s;
  logic [W-1:0] p_scale, p_shr8;
  logic [W-1:0] mul_a, mul_b, mul_lo;
  logic         in_accept, out_load;

  logic         div_start, div_signed, div_done;
  logic [W-1:0] div_dividend, div_quo;

  assign ac1_s = {{16{ac12_q[31]}}, ac12_q[31:16]};
  assign ac2_s = {{16{ac12_q[15]}}, ac12_q[15:0]};
  assign ac3_s = {{16{ac34_q[31]}}, ac34_q[31:16]};
  assign ac4_u = {16'b0, ac34_q[15:0]};
  assign ac5_u = {16'b0, ac56_q[31:16]};
  assign ac6_u = {16'b0, ac56_q[15:0]};
  assign b1_s  = {{16{b12_q[31]}}, b12_q[31:16]};
  assign b2_s  = {{16{b12_q[15]}}, b12_q[15:0]};
  assign mc_s  = {{16{mcmd_q[31]}}, mcmd_q[31:16]};
  assign md_s  = {{16{mcmd_q[15]}}, mcmd_q[15:0]};

  assign p_scale = P_SCALE >> oss_q;
  assign p_shr8  = sra32(r3_q, 5'd8);

  assign in_accept  = in_valid_i && (state_q == S_IDLE);
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = (state_q != S_IDLE);

  // Shared multiplier: only the low word of the product is ever needed.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_T_X1: begin
        mul_a = a_q;
        mul_b = ac5_u;
      end
      S_P_SQ: begin
        mul_a = a_q;
        mul_b = a_q;
      end
      S_P_X1: begin
        mul_a = b2_s;
        mul_b = sq_q;
      end
      S_P_X2: begin
        mul_a = ac2_s;
        mul_b = a_q;
      end
      S_P_B3A: begin
        mul_a = ac3_s;
        mul_b = a_q;
      end
      S_P_B3B: begin
        mul_a = b1_s;
        mul_b = sq_q;
      end
      S_P_B4B: begin
        mul_a = r1_q;
        mul_b = p_scale;
      end
      S_P_B4C: begin
        mul_a = ac4_u;
        mul_b = r2_q;
      end
      S_P_C1: begin
        mul_a = p_shr8;
        mul_b = p_shr8;
      end
      S_P_C2: begin
        mul_a = r1_q;
        mul_b = K_SQ;
      end
      S_P_C3: begin
        mul_a = K_LIN;
        mul_b = r3_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_lo = mul_a * mul_b;

  // The divisor sits in r2_q for both kinds; a zero divisor skips the divide.
  assign div_start    = ((state_q == S_T_CHK) || (state_q == S_P_CHK)) && (r2_q != '0);
  assign div_signed   = (state_q == S_T_CHK);
  assign div_dividend = (state_q == S_T_CHK) ? {mc_s[20:0], 11'b0} :
                        (r1_q[W-1] ? r1_q : {r1_q[W-2:0], 1'b0});

  bsc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .signed_i   (div_signed),
    .dividend_i (div_dividend),
    .divisor_i  (r2_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_accept) state_d = in_data_i.kind ? S_P_SQ : S_T_X1;
      S_T_X1:  state_d = S_T_DEN;
      S_T_DEN: state_d = S_T_CHK;
      S_T_CHK: state_d = (r2_q == '0) ? S_DONE : S_T_DIV;
      S_T_DIV: if (div_done) state_d = S_T_VAL;
      S_T_VAL: state_d = S_DONE;
      S_P_SQ:  state_d = S_P_X1;
      S_P_X1:  state_d = S_P_X2;
      S_P_X2:  state_d = S_P_B3A;
      S_P_B3A: state_d = S_P_B3B;
      S_P_B3B: state_d = S_P_B3C;
      S_P_B3C: state_d = S_P_B4A;
      S_P_B4A: state_d = S_P_B4B;
      S_P_B4B: state_d = S_P_B4C;
      S_P_B4C: state_d = S_P_CHK;
      S_P_CHK: state_d = (r2_q == '0) ? S_DONE : S_P_DIV;
      S_P_DIV: if (div_done) state_d = S_P_C1;
      S_P_C1:  state_d = S_P_C2;
      S_P_C2:  state_d = S_P_C3;
      S_P_C3:  state_d = S_P_C4;
      S_P_C4:  state_d = S_P_C5;
      S_P_C5:  state_d = S_P_VAL;
      S_P_VAL: state_d = S_DONE;
      S_DONE:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      temp_term_q <= '0;
      ac12_q      <= '0;
      ac34_q      <= '0;
      ac56_q      <= '0;
      b12_q       <= '0;
      mcmd_q      <= '0;
      oss_q       <= 2'd3;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if ((state_q == S_T_DIV) && div_done) begin
        temp_term_q <= r1_q + div_quo;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bsc_pkg::REG_AC1_AC2:  ac12_q <= cfg_wdata_i;
          bsc_pkg::REG_AC3_AC4:  ac34_q <= cfg_wdata_i;
          bsc_pkg::REG_AC5_AC6:  ac56_q <= cfg_wdata_i;
          bsc_pkg::REG_B1_B2:    b12_q  <= cfg_wdata_i;
          bsc_pkg::REG_MC_MD:    mcmd_q <= cfg_wdata_i;
          bsc_pkg::REG_OVERSAMP: oss_q  <= cfg_wdata_i[bsc_pkg::OSS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath: at most one multiply and two adds per step.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          kind_q <= in_data_i.kind;
          raw_q  <= in_data_i.raw_value;
          a_q    <= in_data_i.kind ? (temp_term_q - T_OFFSET) :
                    ({{PAD_W{1'b0}}, in_data_i.raw_value} - ac6_u);
        end
      end
      S_T_X1:  r1_q <= sra32(mul_lo, 5'd15);
      S_T_DEN: r2_q <= r1_q + md_s;
      S_T_CHK: begin
        if (r2_q == '0) begin
          val_q <= '0;
          err_q <= 1'b1;
        end
      end
      S_T_VAL: begin
        val_q <= sra32(temp_term_q + T_ROUND, 5'd4);
        err_q <= 1'b0;
      end
      S_P_SQ:  sq_q <= sra32(mul_lo, 5'd12);
      S_P_X1:  r1_q <= sra32(mul_lo, 5'd11);
      S_P_X2:  r2_q <= sra32(mul_lo, 5'd11);
      S_P_B3A: begin
        r1_q <= r1_q + r2_q;
        r2_q <= sra32(mul_lo, 5'd13);
      end
      S_P_B3B: begin
        r1_q <= ({ac1_s[W-3:0], 2'b0} + r1_q) << oss_q;
        r3_q <= sra32(mul_lo, 5'd16);
      end
      S_P_B3C: begin
        r1_q <= sra32(r1_q + B_ROUND, 5'd2);
        r2_q <= r2_q + r3_q;
      end
      S_P_B4A: begin
        r1_q <= {{PAD_W{1'b0}}, raw_q} - r1_q;
        r2_q <= sra32(r2_q + B_ROUND, 5'd2);
      end
      S_P_B4B: begin
        r1_q <= mul_lo;
        r2_q <= r2_q + B4_BIAS;
      end
      S_P_B4C: r2_q <= mul_lo >> 15;
      S_P_CHK: begin
        if (r2_q == '0) begin
          val_q <= '0;
          err_q <= 1'b1;
        end
      end
      S_P_DIV: begin
        // Large B7 was divided unshifted; the doubling comes afterwards.
        if (div_done) begin
          r3_q <= r1_q[W-1] ? {div_quo[W-2:0], 1'b0} : div_quo;
        end
      end
      S_P_C1:  r1_q <= mul_lo;
      S_P_C2:  r1_q <= sra32(mul_lo, 5'd16);
      S_P_C3:  r2_q <= sra32(mul_lo, 5'd16);
      S_P_C4:  r1_q <= r1_q + r2_q;
      S_P_C5:  r1_q <= sra32(r1_q + K_OFS, 5'd4);
      S_P_VAL: begin
        val_q <= r3_q + r1_q;
        err_q <= 1'b0;
      end
      S_DONE: begin
        if (out_load) begin
          out_data_q.result_kind <= kind_q;
          out_data_q.value       <= $signed(val_q);
          out_data_q.div_error   <= err_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `BSC_ASSERT(div_done_in_wait, div_done |-> (state_q == S_T_DIV || state_q == S_P_DIV), clk_i, rst_ni)
  `BSC_ASSERT(b5_only_after_divide, !$stable(temp_term_q) |-> $past(state_q == S_T_DIV), clk_i, rst_ni)
  `BSC_ASSERT(result_waits_for_room, (state_q == S_DONE && out_valid_q && out_stall_i) |=> (state_q == S_DONE), clk_i, rst_ni)

endmodule

// File: hdl/bsc_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, optional signed mode.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bsc_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      signed_i,
  input  logic [bsc_pkg::DATA_W-1:0] dividend_i,
  input  logic [bsc_pkg::DATA_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [bsc_pkg::DATA_W-1:0] quotient_o
);

  localparam int W = bsc_pkg::DATA_W;
  localparam logic [bsc_pkg::CNT_W-1:0] LastCnt = bsc_pkg::CNT_W'(W - 1);

  logic                      busy_q, fix_q, done_q;
  logic [bsc_pkg::CNT_W-1:0] cnt_q;
  logic [W-1:0]              rem_q, quo_q, dvs_q;
  logic                      neg_q;

  logic [W-1:0] dend_mag, dvs_mag;
  logic [W:0]   rem_sh, diff;

  // Signed mode works on magnitudes and fixes the sign at the end, which
  // gives truncation toward zero.
  assign dend_mag = (signed_i && dividend_i[W-1]) ? ({W{1'b0}} - dividend_i) : dividend_i;
  assign dvs_mag  = (signed_i && divisor_i[W-1])  ? ({W{1'b0}} - divisor_i)  : divisor_i;

  assign rem_sh = {rem_q, quo_q[W-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fix_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + bsc_pkg::CNT_W'(1);
        if (cnt_q == LastCnt) begin
          busy_q <= 1'b0;
          fix_q  <= 1'b1;
        end
      end else if (fix_q) begin
        fix_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dend_mag;
      dvs_q <= dvs_mag;
      neg_q <= signed_i & (dividend_i[W-1] ^ divisor_i[W-1]);
    end else if (busy_q) begin
      if (!diff[W]) begin
        rem_q <= diff[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b0};
      end
    end else if (fix_q) begin
      if (neg_q) begin
        quo_q <= {W{1'b0}} - quo_q;
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  `BSC_ASSERT_NEVER(div_busy_and_fix, busy_q && fix_q, clk_i, rst_ni)
  `BSC_ASSERT_NEVER(div_start_while_busy, start_i && (busy_q || fix_q), clk_i, rst_ni)
  `BSC_ASSERT(div_done_after_fix, done_q |-> $past(fix_q), clk_i, rst_ni)

endmodule
